### rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int SYMBOL_BITS_DEF  = 16;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int WORD_BITS_DEF    = 32;

	// fixed field widths of the channels
	localparam int SYMBOL_W = 16;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int WORD_W   = 32;
	localparam int TOTAL_W  = 32;

	// output queue depth, power of two
	localparam int OUT_DEPTH = 8;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_ENCODE = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_word;
		logic [LEN_W-1:0]   valid_bits;
		logic               last_word;
		logic [TOTAL_W-1:0] total_bits;
	} result_t;

endpackage

### rtl/hcbp_pix_if.sv
// ----------------------------------------------------------------------------
// hcbp_pix_if
// Input channel: table loads and pixels to encode.
// ----------------------------------------------------------------------------
interface hcbp_pix_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
	logic [hcbp_pkg::CODE_W-1:0]   code_bits;
	logic [hcbp_pkg::LEN_W-1:0]    code_length;
	logic                         final_pixel;

	modport source (output valid, kind, symbol, code_bits, code_length, final_pixel,
		input ready);
	modport sink (input valid, kind, symbol, code_bits, code_length, final_pixel,
		output ready);
endinterface

### rtl/hcbp_word_if.sv
// ----------------------------------------------------------------------------
// hcbp_word_if
// Output channel: packed words of the encoded stream.
// ----------------------------------------------------------------------------
interface hcbp_word_if;
	logic                          valid;
	logic                          ready;
	logic [hcbp_pkg::WORD_W-1:0]   packed_word;
	logic [hcbp_pkg::LEN_W-1:0]    valid_bits;
	logic                          last_word;
	logic [hcbp_pkg::TOTAL_W-1:0]  total_bits;

	modport source (output valid, packed_word, valid_bits, last_word, total_bits,
		input ready);
	modport sink (input valid, packed_word, valid_bits, last_word, total_bits,
		output ready);
endinterface

### rtl/hcbp_table.sv
// ----------------------------------------------------------------------------
// hcbp_table
// Code table memory: code bits and length per symbol, one write and one
// registered read per cycle, length cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module hcbp_table #(
	parameter int SYMBOL_BITS  = hcbp_pkg::SYMBOL_BITS_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [SYMBOL_BITS-1:0]       wr_addr,
	input  logic [MAX_CODE_LEN-1:0]      wr_code,
	input  logic [hcbp_pkg::LEN_W-1:0]   wr_len,
	input  logic                         rd_en,
	input  logic [SYMBOL_BITS-1:0]       rd_addr,
	output logic [MAX_CODE_LEN-1:0]      rd_code,
	output logic [hcbp_pkg::LEN_W-1:0]   rd_len,
	output logic                         busy
);
	localparam int DEPTH   = 2 ** SYMBOL_BITS;
	localparam int ENTRY_W = MAX_CODE_LEN + hcbp_pkg::LEN_W;

	logic [ENTRY_W-1:0]     mem [DEPTH];
	logic [ENTRY_W-1:0]     rd_data_q;
	logic                   clr_busy_q;
	logic [SYMBOL_BITS-1:0] clr_addr_q;

	logic                   mem_we;
	logic [SYMBOL_BITS-1:0] mem_waddr;
	logic [ENTRY_W-1:0]     mem_wdata;

	// clearing sweep owns the write port until every entry is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {SYMBOL_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_en;
			mem_waddr = wr_addr;
			mem_wdata = {wr_len, wr_code};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_data_q[MAX_CODE_LEN-1:0];
	assign rd_len  = rd_data_q[ENTRY_W-1:MAX_CODE_LEN];
	assign busy    = clr_busy_q;

	a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr_en && !rd_en)
		else $error("table accessed during clearing sweep");

endmodule

### rtl/hcbp_out_fifo.sv
// ----------------------------------------------------------------------------
// hcbp_out_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module hcbp_out_fifo #(
	parameter int DEPTH = hcbp_pkg::OUT_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_n,
	input  hcbp_pkg::result_t             push_d0,
	input  hcbp_pkg::result_t             push_d1,
	input  logic                          pop,
	output hcbp_pkg::result_t             head,
	output logic [$clog2(DEPTH):0]        count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	hcbp_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_n);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_pair_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2 && !pop) |=> count_q == $past(count_q) + CW'(2))
		else $error("double push lost an entry");

endmodule

### rtl/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman encoder packing variable-length codes into words.
// ----------------------------------------------------------------------------
// pixels channel: kind 0 loads symbol's code bits and length into the table
// (length clamped to the smaller of MAX_CODE_LEN and WORD_BITS), kind 1
// encodes one pixel; final_pixel on an encode flushes the partial word.
// words channel: full words with valid_bits = WORD_BITS, and on the final
// pixel one more word with last_word set and the bit count of the image.
// one transaction per cycle is taken on pixels while pixels.ready is high;
// a load is seen by an encode in the very next cycle. an encode reads the
// table in its accept cycle, packs in the next, and its words are taken from
// the result queue. throughput is one pixel per cycle while pixels.ready is
// high, bounded by the single table read port; a pixel that completes a word
// and also flushes yields two words, which drain one per cycle while
// words.ready is high from an eight-entry result queue. after reset the table
// is cleared one entry per cycle, and pixels.ready stays low until every
// entry is zero. when the words receiver stalls the queue fills and
// pixels.ready drops once it cannot hold the worst case of pixels in flight.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
	parameter int SYMBOL_BITS  = hcbp_pkg::SYMBOL_BITS_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int WORD_BITS    = hcbp_pkg::WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hcbp_pix_if.sink     pixels,
	hcbp_word_if.source  words
);
	localparam int CAP   = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
	localparam int FW    = $clog2(WORD_BITS);
	localparam int SW    = FW + 1;
	localparam int DEPTH = hcbp_pkg::OUT_DEPTH;
	localparam int QCW   = $clog2(DEPTH) + 1;
	localparam int TW    = hcbp_pkg::TOTAL_W;
	localparam int LW    = hcbp_pkg::LEN_W;

	logic                    accept;
	logic                    busy;
	logic                    tbl_wr;
	logic                    tbl_rd;
	logic [LW-1:0]           load_len;
	logic [MAX_CODE_LEN-1:0] rd_code;
	logic [LW-1:0]           rd_len;

	logic                    valid_s1;
	logic                    fin_s1;

	logic [WORD_BITS-1:0]    acc_q;
	logic [FW-1:0]           fill_q;
	logic [TW-1:0]           total_q;

	logic [MAX_CODE_LEN-1:0] code_mask;
	logic [2*WORD_BITS-1:0]  merged;
	logic [SW-1:0]           fill_sum;
	logic                    word_full;
	logic [TW:0]             total_sum;
	logic [TW-1:0]           total_nx;
	logic [WORD_BITS-1:0]    acc_nx;
	logic [FW-1:0]           fill_nx;

	hcbp_pkg::result_t       full_res;
	hcbp_pkg::result_t       flush_res;
	hcbp_pkg::result_t       push_d0;
	hcbp_pkg::result_t       head;
	logic [1:0]              push_n;
	logic [QCW-1:0]          q_count;
	logic [QCW:0]            q_need;

	// ready reserves room for two results of the pixel in the pack stage and
	// two of the one being accepted
	assign q_need       = (QCW+1)'(q_count) + (valid_s1 ? (QCW+1)'(2) : '0);
	assign pixels.ready = !busy && (q_need <= (QCW+1)'(DEPTH - 2));
	assign accept       = pixels.valid && pixels.ready;
	assign tbl_wr       = accept && (pixels.kind == hcbp_pkg::KIND_LOAD);
	assign tbl_rd       = accept && (pixels.kind == hcbp_pkg::KIND_ENCODE);
	assign load_len     = (pixels.code_length > LW'(CAP)) ? LW'(CAP) : pixels.code_length;

	hcbp_table #(
		.SYMBOL_BITS  (SYMBOL_BITS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.wr_addr (pixels.symbol[SYMBOL_BITS-1:0]),
		.wr_code (pixels.code_bits[MAX_CODE_LEN-1:0]),
		.wr_len  (load_len),
		.rd_en   (tbl_rd),
		.rd_addr (pixels.symbol[SYMBOL_BITS-1:0]),
		.rd_code (rd_code),
		.rd_len  (rd_len),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tbl_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_rd) begin
			fin_s1 <= pixels.final_pixel;
		end
	end

	// pack stage: place the masked code above the buffered bits
	always_comb begin
		code_mask = ~({MAX_CODE_LEN{1'b1}} << rd_len);
		merged    = ((2*WORD_BITS)'(rd_code & code_mask) << fill_q)
			| (2*WORD_BITS)'(acc_q);
		fill_sum  = SW'(fill_q) + SW'(rd_len);
		word_full = fill_sum >= SW'(WORD_BITS);
		total_sum = (TW+1)'(total_q) + (TW+1)'(rd_len);
		total_nx  = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];
		if (word_full) begin
			acc_nx  = merged[2*WORD_BITS-1:WORD_BITS];
			fill_nx = FW'(fill_sum - SW'(WORD_BITS));
		end else begin
			acc_nx  = merged[WORD_BITS-1:0];
			fill_nx = FW'(fill_sum);
		end
	end

	always_comb begin
		full_res.packed_word  = hcbp_pkg::WORD_W'(merged[WORD_BITS-1:0]);
		full_res.valid_bits   = LW'(WORD_BITS);
		full_res.last_word    = 1'b0;
		full_res.total_bits   = total_nx;
		flush_res.packed_word = hcbp_pkg::WORD_W'(acc_nx);
		flush_res.valid_bits  = LW'(fill_nx);
		flush_res.last_word   = 1'b1;
		flush_res.total_bits  = total_nx;
		push_d0 = word_full ? full_res : flush_res;
		push_n  = valid_s1 ? (2'(word_full) + 2'(fin_s1)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (valid_s1) begin
			if (fin_s1) begin
				acc_q   <= '0;
				fill_q  <= '0;
				total_q <= '0;
			end else begin
				acc_q   <= acc_nx;
				fill_q  <= fill_nx;
				total_q <= total_nx;
			end
		end
	end

	hcbp_out_fifo #(
		.DEPTH (DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_n  (push_n),
		.push_d0 (push_d0),
		.push_d1 (flush_res),
		.pop     (words.valid && words.ready),
		.head    (head),
		.count   (q_count)
	);

	assign words.valid       = q_count != '0;
	assign words.packed_word = head.packed_word;
	assign words.valid_bits  = head.valid_bits;
	assign words.last_word   = head.last_word;
	assign words.total_bits  = head.total_bits;

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fin_s1) |=> fill_q == '0 && total_q == '0 && acc_q == '0)
		else $error("packer state not cleared after final pixel");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept)
		else $error("pixel accepted during table clearing");

endmodule
